[hdl/frk_pkg.sv]
package frk_pkg;

  localparam int KEY_BITS   = 32;
  localparam int COUNT_BITS = 16;
  localparam int RANK_BITS  = 5;

  typedef enum logic [1:0] {
    CMD_INC   = 2'd0,
    CMD_CLR   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [KEY_BITS-1:0]   content_key;
  } in_item_t;

  typedef struct packed {
    logic [RANK_BITS-1:0]  rank;
    logic [COUNT_BITS-1:0] hit_count;
    logic                  dropped;
  } out_item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic                upd;
    logic                sort;
    logic                odd;
    logic                ins;
    cmd_t                cmd;
    logic [KEY_BITS-1:0] key;
  } cell_ctl_t;

endpackage

[hdl/frk_cell.sv]
module frk_cell #(
  parameter int TABLE_DEPTH = 16,
  parameter int IDX         = 0
) (
  input  logic                               clk,
  input  frk_pkg::cell_ctl_t                 ctl,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]   occ,
  input  frk_pkg::entry_t                    left,
  input  frk_pkg::entry_t                    right,
  output frk_pkg::entry_t                    ent,
  output logic                               match
);

  localparam int  OW     = $clog2(TABLE_DEPTH + 1);
  localparam bit  IS_ODD = (IDX % 2) == 1;

  frk_pkg::entry_t ent_next;
  logic            in_use;
  logic            right_use;
  logic            take_right;
  logic            take_left;

  assign in_use    = OW'(IDX) < occ;
  assign right_use = OW'(IDX + 1) < occ;
  assign match     = in_use && (ent.key == ctl.key);

  // odd-even transposition: swap only on strictly smaller left count (stable)
  assign take_right = (IS_ODD == ctl.odd) && right_use && (ent.count < right.count);
  assign take_left  = (IS_ODD != ctl.odd) && (IDX > 0) && in_use &&
                      (left.count < ent.count);

  always_comb begin
    ent_next = ent;
    if (ctl.sort) begin
      if (take_right) begin
        ent_next = right;
      end else if (take_left) begin
        ent_next = left;
      end
    end else if (ctl.upd) begin
      case (ctl.cmd)
        frk_pkg::CMD_INC: begin
          if (match) begin
            if (ent.count != '1) begin
              ent_next.count = ent.count + frk_pkg::COUNT_BITS'(1);
            end
          end else if (ctl.ins && (occ == OW'(IDX))) begin
            ent_next.key   = ctl.key;
            ent_next.count = frk_pkg::COUNT_BITS'(1);
          end
        end
        frk_pkg::CMD_CLR: begin
          if (match) begin
            ent_next.count = '0;
          end
        end
        default: begin
          ent_next = ent;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule

[hdl/frequency_ranked_key_table.sv]
// Channel  | Signals                   | Beat
// req      | req_valid, req_stall, req | one command and content key
// rsp      | rsp_valid, rsp_stall, rsp | rank, hit count, dropped flag
//
// Increment: rsp_valid rises after an update step, TABLE_DEPTH odd-even sort
// rounds along the cell row and a lookup step. Reset count and query skip the
// sort rounds. One item at a time; the next req beat is taken the cycle after
// the result is loaded, even while rsp is stalled.
// Reset empties the table (occupancy to zero); entries need no clearing.
// A stalled rsp holds the finished result and the table waits in lookup.
module frequency_ranked_key_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  frk_pkg::in_item_t   req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output frk_pkg::out_item_t  rsp
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int OW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_UPD  = 4'b0010,
    ST_SORT = 4'b0100,
    ST_FIND = 4'b1000
  } state_t;

  state_t                      state;
  state_t                      state_next;
  frk_pkg::cmd_t               cmd;
  logic [frk_pkg::KEY_BITS-1:0] key;
  logic [OW-1:0]               occ;
  logic [IW-1:0]               sort_cnt;
  logic                        drop;

  frk_pkg::cell_ctl_t          ctl;
  frk_pkg::entry_t             ent   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]      match;
  logic                        hit;
  logic                        ins;
  logic [IW-1:0]               pos;
  logic [frk_pkg::COUNT_BITS-1:0] cnt_sel;
  logic [IW:0]                 pos_p1;
  logic                        req_take;
  logic                        rsp_free;

  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  assign hit = |match;
  assign ins = (state == ST_UPD) && (cmd == frk_pkg::CMD_INC) && !hit &&
               (occ != OW'(TABLE_DEPTH));

  assign ctl.upd  = (state == ST_UPD);
  assign ctl.sort = (state == ST_SORT);
  assign ctl.odd  = sort_cnt[0];
  assign ctl.ins  = ins;
  assign ctl.cmd  = cmd;
  assign ctl.key  = key;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    frk_pkg::entry_t lft;
    frk_pkg::entry_t rgt;
    if (g == 0) begin : g_first
      assign lft = '0;
    end else begin : g_mid_l
      assign lft = ent[g-1];
    end
    if (g == TABLE_DEPTH - 1) begin : g_last
      assign rgt = '0;
    end else begin : g_mid_r
      assign rgt = ent[g+1];
    end
    frk_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX         (g)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .occ   (occ),
      .left  (lft),
      .right (rgt),
      .ent   (ent[g]),
      .match (match[g])
    );
  end

  // keys are unique, so at most one match: OR the position and count
  always_comb begin
    pos     = '0;
    cnt_sel = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (match[i]) begin
        pos     = pos | IW'(i);
        cnt_sel = cnt_sel | ent[i].count;
      end
    end
  end

  assign pos_p1 = {1'b0, pos} + (IW+1)'(1);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_take) begin
          state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        state_next = (cmd == frk_pkg::CMD_INC) ? ST_SORT : ST_FIND;
      end
      ST_SORT: begin
        if (sort_cnt == IW'(TABLE_DEPTH - 1)) begin
          state_next = ST_FIND;
        end
      end
      ST_FIND: begin
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      occ       <= '0;
      rsp_valid <= 1'b0;
      sort_cnt  <= '0;
    end else begin
      state <= state_next;
      if (ins) begin
        occ <= occ + OW'(1);
      end
      if (state == ST_UPD) begin
        sort_cnt <= '0;
      end else if (state == ST_SORT) begin
        sort_cnt <= sort_cnt + IW'(1);
      end
      if (state == ST_FIND && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      cmd <= req.cmd;
      key <= req.content_key;
    end
    if (state == ST_UPD) begin
      drop <= (cmd == frk_pkg::CMD_INC) && !hit && (occ == OW'(TABLE_DEPTH));
    end
    if (state == ST_FIND && rsp_free) begin
      rsp.rank      <= hit ? frk_pkg::RANK_BITS'(pos_p1) : '0;
      rsp.hit_count <= hit ? cnt_sel : '0;
      rsp.dropped   <= drop;
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OW'(TABLE_DEPTH))
    else $error("occupancy above table depth");

  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (occ == $past(occ)) || (occ == $past(occ) + OW'(1)))
    else $error("occupancy moved by more than one entry");

  a_key_unique: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIND) |-> $onehot0(match))
    else $error("key held by more than one entry");

  a_drop_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.dropped) |-> (rsp.rank == '0) && (rsp.hit_count == '0))
    else $error("dropped beat carries a rank or count");
`endif

endmodule
